// ----- rtl/bsm_pkg.sv -----
package bsm_pkg;

    localparam int CELL_SIZE = 8;
    localparam int GRID      = 5;

    localparam int T_W        = 17;
    localparam int PT_W       = 10;
    localparam int STEP_W     = 12;
    localparam int MASK_W     = GRID * GRID;
    localparam int W_W        = 33;
    localparam int ACC_W      = 42;
    localparam int D_W        = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [T_W-1:0]    T_ONE      = 17'h10000;
    localparam logic [STEP_W-1:0] STEP_RESET = 12'd328;

    // doubled-coordinate offset of the grid's left/top edge (2.5 cells)
    localparam logic signed [D_W-1:0] CELL_OFFSET = D_W'(5 * CELL_SIZE);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X   = 3'd0,
        CFG_START_Y   = 3'd1,
        CFG_CONTROL_X = 3'd2,
        CFG_CONTROL_Y = 3'd3,
        CFG_END_X     = 3'd4,
        CFG_END_Y     = 3'd5,
        CFG_T_STEP    = 3'd6,
        CFG_CELL_MASK = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_W0,
        S_W1,
        S_W2,
        S_ACC,
        S_HIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        W_UU,
        W_TU,
        W_TT
    } t_wsel;

    typedef enum logic [1:0] {
        P_START,
        P_CTRL,
        P_END
    } t_psel;

    typedef struct packed {
        logic            command;
        logic [PT_W-1:0] probe_x;
        logic [PT_W-1:0] probe_y;
    } t_req;

    typedef struct packed {
        logic [PT_W-1:0] pos_x;
        logic [PT_W-1:0] pos_y;
        logic            hit;
    } t_rsp;

    typedef struct packed {
        logic  load_req;
        logic  w_en;
        t_wsel wsel;
        logic  clr_acc;
        logic  acc_en;
        t_psel psel;
        logic  hit_en;
        logic  out_load;
    } t_cmd;

    // doubled-coordinate span of cell k along one axis, relative to grid edge
    function automatic logic signed [D_W-1:0] cell_lo(input int k);
        cell_lo = D_W'(2 * k * CELL_SIZE);
    endfunction

    function automatic logic signed [D_W-1:0] cell_hi(input int k);
        cell_hi = D_W'((2 * k + 2) * CELL_SIZE);
    endfunction

endpackage

// ----- rtl/bsm_ctrl.sv -----
module bsm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_cmd,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output bsm_pkg::t_cmd o_cmd
);
    import bsm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = i_req_cmd ? S_HIT : S_W0;
                end
            end
            S_W0: begin
                o_cmd.w_en    = 1'b1;
                o_cmd.wsel    = W_UU;
                o_cmd.clr_acc = 1'b1;
                n_state       = S_W1;
            end
            S_W1: begin
                o_cmd.w_en   = 1'b1;
                o_cmd.wsel   = W_TU;
                o_cmd.acc_en = 1'b1;
                o_cmd.psel   = P_START;
                n_state      = S_W2;
            end
            S_W2: begin
                o_cmd.w_en   = 1'b1;
                o_cmd.wsel   = W_TT;
                o_cmd.acc_en = 1'b1;
                o_cmd.psel   = P_CTRL;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.psel   = P_END;
                n_state      = S_DONE;
            end
            S_HIT: begin
                o_cmd.hit_en = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold the finished item until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bsm_dpath.sv -----
module bsm_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  bsm_pkg::t_req                    i_req,
    input  bsm_pkg::t_cmd                    i_cmd,
    output bsm_pkg::t_rsp                    o_rsp
);
    import bsm_pkg::*;

    // configuration
    logic [PT_W-1:0]   r_start_x, r_start_y;
    logic [PT_W-1:0]   r_control_x, r_control_y;
    logic [PT_W-1:0]   r_end_x, r_end_y;
    logic [STEP_W-1:0] r_t_step;
    logic [MASK_W-1:0] r_cell_mask;

    // architectural state
    logic [T_W-1:0]  r_path;
    logic            r_fwd;
    logic [PT_W-1:0] r_cur_x, r_cur_y;

    // working registers
    t_req             r_req;
    logic [W_W-1:0]   r_w;
    logic [ACC_W-1:0] r_acc_x, r_acc_y;
    logic             r_hit;
    t_rsp             r_rsp;

    logic [T_W-1:0]   t_c, u_c, mul_a, mul_b;
    logic [2*T_W-1:0] w_prod;
    logic [W_W-1:0]   n_w;
    logic [PT_W-1:0]  pt_x, pt_y;
    logic [PT_W+W_W-1:0] mac_x, mac_y;
    logic [T_W:0]     t_sum;
    logic [T_W-1:0]   n_path;
    logic             n_fwd;
    logic signed [D_W-1:0] dx, dy;
    logic [GRID-1:0]  col_in, row_in;
    logic             n_hit;
    logic             is_tick;

    assign o_rsp   = r_rsp;
    assign is_tick = !r_req.command;

    // clamp t to one before use
    assign t_c = (r_path > T_ONE) ? T_ONE : r_path;
    assign u_c = T_ONE - t_c;

    // shared weight multiplier: u*u, 2*t*u, t*t
    always_comb begin
        case (i_cmd.wsel)
            W_UU: begin
                mul_a = u_c;
                mul_b = u_c;
            end
            W_TU: begin
                mul_a = t_c;
                mul_b = u_c;
            end
            W_TT: begin
                mul_a = t_c;
                mul_b = t_c;
            end
            default: begin
                mul_a = t_c;
                mul_b = t_c;
            end
        endcase
    end

    assign w_prod = {{T_W{1'b0}}, mul_a} * {{T_W{1'b0}}, mul_b};
    assign n_w    = (i_cmd.wsel == W_TU) ? {w_prod[W_W-2:0], 1'b0} : w_prod[W_W-1:0];

    always_comb begin
        case (i_cmd.psel)
            P_START: begin
                pt_x = r_start_x;
                pt_y = r_start_y;
            end
            P_CTRL: begin
                pt_x = r_control_x;
                pt_y = r_control_y;
            end
            P_END: begin
                pt_x = r_end_x;
                pt_y = r_end_y;
            end
            default: begin
                pt_x = r_end_x;
                pt_y = r_end_y;
            end
        endcase
    end

    assign mac_x = {{W_W{1'b0}}, pt_x} * {{PT_W{1'b0}}, r_w};
    assign mac_y = {{W_W{1'b0}}, pt_y} * {{PT_W{1'b0}}, r_w};

    // step t, clamp at the ends and flip only on overshoot
    assign t_sum = {1'b0, t_c} + {{(T_W+1-STEP_W){1'b0}}, r_t_step};

    always_comb begin
        n_path = t_c;
        n_fwd  = r_fwd;
        if (r_fwd) begin
            if (t_sum > {1'b0, T_ONE}) begin
                n_path = T_ONE;
                n_fwd  = 1'b0;
            end else begin
                n_path = t_sum[T_W-1:0];
            end
        end else begin
            if ({{(T_W-STEP_W){1'b0}}, r_t_step} > t_c) begin
                n_path = '0;
                n_fwd  = 1'b1;
            end else begin
                n_path = t_c - {{(T_W-STEP_W){1'b0}}, r_t_step};
            end
        end
    end

    // hit test in doubled coordinates relative to the grid edge
    assign dx = $signed({2'b00, r_req.probe_x, 1'b0}) - $signed({2'b00, r_cur_x, 1'b0})
                + CELL_OFFSET;
    assign dy = $signed({2'b00, r_req.probe_y, 1'b0}) - $signed({2'b00, r_cur_y, 1'b0})
                + CELL_OFFSET;

    always_comb begin
        n_hit = 1'b0;
        for (int k = 0; k < GRID; k++) begin
            col_in[k] = (dx >= cell_lo(k)) && (dx <= cell_hi(k));
            row_in[k] = (dy >= cell_lo(k)) && (dy <= cell_hi(k));
        end
        for (int c = 0; c < GRID; c++) begin
            for (int r = 0; r < GRID; r++) begin
                n_hit = n_hit | (r_cell_mask[c*GRID+r] & col_in[c] & row_in[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_control_x <= '0;
            r_control_y <= '0;
            r_end_x     <= '0;
            r_end_y     <= '0;
            r_t_step    <= STEP_RESET;
            r_cell_mask <= '0;
            r_path      <= '0;
            r_fwd       <= 1'b1;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_X:   r_start_x   <= i_cfg_data[PT_W-1:0];
                    CFG_START_Y:   r_start_y   <= i_cfg_data[PT_W-1:0];
                    CFG_CONTROL_X: r_control_x <= i_cfg_data[PT_W-1:0];
                    CFG_CONTROL_Y: r_control_y <= i_cfg_data[PT_W-1:0];
                    CFG_END_X:     r_end_x     <= i_cfg_data[PT_W-1:0];
                    CFG_END_Y:     r_end_y     <= i_cfg_data[PT_W-1:0];
                    CFG_T_STEP:    r_t_step    <= i_cfg_data[STEP_W-1:0];
                    CFG_CELL_MASK: r_cell_mask <= i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.out_load && is_tick) begin
                r_path  <= n_path;
                r_fwd   <= n_fwd;
                r_cur_x <= r_acc_x[ACC_W-1:ACC_W-PT_W];
                r_cur_y <= r_acc_y[ACC_W-1:ACC_W-PT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.w_en) begin
            r_w <= n_w;
        end
        if (i_cmd.clr_acc) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc_x <= r_acc_x + mac_x[ACC_W-1:0];
            r_acc_y <= r_acc_y + mac_y[ACC_W-1:0];
        end
        if (i_cmd.hit_en) begin
            r_hit <= n_hit;
        end
        if (i_cmd.out_load) begin
            if (is_tick) begin
                r_rsp.pos_x <= r_acc_x[ACC_W-1:ACC_W-PT_W];
                r_rsp.pos_y <= r_acc_y[ACC_W-1:ACC_W-PT_W];
                r_rsp.hit   <= 1'b0;
            end else begin
                r_rsp.pos_x <= r_cur_x;
                r_rsp.pos_y <= r_cur_y;
                r_rsp.hit   <= r_hit;
            end
        end
    end

endmodule

// ----- rtl/bezier_sprite_mover_unit.sv -----
// Channel   Direction  Handshake                  Payload
// request   in         i_req_valid / o_req_ready  i_req  (command, probe_x, probe_y)
// result    out        o_rsp_valid / i_rsp_ready  o_rsp  (pos_x, pos_y, hit)
// config    in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// A tick request steps through states W0, W1, W2, ACC and DONE: one 17x17
// multiplier forms the weights u*u, 2*t*u and t*t in turn, and two 10x33
// multiply-accumulators fold each weight into x and y the cycle after.
// A hit request steps through states HIT and DONE: ten parallel range
// checks (five columns, five rows) are made in HIT.
// The next request is accepted the cycle after the result is loaded into
// the output register; a stalled result blocks at most one more request.
// Reset (synchronous, active low) restores t = 0, forward travel, position
// (0,0), all points 0, cell mask 0 and t_step 328.
module bezier_sprite_mover_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  bsm_pkg::t_req                   i_req,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output bsm_pkg::t_rsp                   o_rsp
);
    import bsm_pkg::*;

    t_cmd cmd;

    // sequence the request: weights and accumulation for ticks, one compare for hits
    bsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_cmd   (i_req.command),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_cmd       (cmd)
    );

    // hold configuration, curve state, arithmetic and the result register
    bsm_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_rsp      (o_rsp)
    );

    // an accepted request always takes the block out of idle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready
    ) else $error("request accepted but block still ready");

    // a result only appears after the block has been working on a request
    a_result_from_work: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(!o_req_ready)
    ) else $error("result appeared without a request in flight");

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_rsp_valid || i_rsp_ready)
    ) else $error("output register loaded over a pending result");

endmodule
